FILE: rtl/core/chained_hash_table_engine_assert.svh
// Assertion macros for the chained hash table engine.
// Included by the top level; no other dependencies.
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

// cond must never hold outside reset
`define CHT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// a at one edge implies b at the next
`define CHT_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/core/cht_pkg.sv
// Shared types and constants for the chained hash table engine.
// No dependencies.
package cht_pkg;

  localparam int CFG_W = 11;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_GET_KEY = 3'd1;
  localparam logic [2:0] CMD_DEL_KEY = 3'd2;
  localparam logic [2:0] CMD_GET_H   = 3'd3;
  localparam logic [2:0] CMD_DEL_H   = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] hash;
    logic [63:0] payload;
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_HEAD, ST_ADD, ST_FIRST, ST_CHECK, ST_FREE, ST_DONE
  } state_t;

endpackage

FILE: rtl/core/chained_hash_table_engine.sv
// Separate-chaining hash table engine, top level.
// Depends on cht_pkg, cht_front, cht_back and the assertion header.
//
// Input items carry key bytes; the hash h = 31*h + signed byte builds up
// until an item with in_key_last, which runs the command and yields one
// result item (unused commands yield none). An executed command runs a
// bit-serial bucket modulo, then reads the bucket head and, for lookups
// and deletes, each chain node in turn; a delete adds a step that frees
// the matched node.
// A two-entry queue decouples the input from the back end, so new items
// are taken while a command runs. Results sit in an output register and
// wait there while out_ready is low; the back end stalls behind it.
// After reset a clearing pass over MAX_BUCKETS entries empties the bucket
// heads, during which in_ready is low; cfg writes are taken at any time.
// cfg_we writes bucket_count, which must change only while idle.
`include "chained_hash_table_engine_assert.svh"

module chained_hash_table_engine #(
  parameter int NODE_COUNT  = 1024,
  parameter int MAX_BUCKETS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cht_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_cmd,
  input  logic [7:0]                in_key_byte,
  input  logic                      in_byte_valid,
  input  logic                      in_key_last,
  input  logic [31:0]               in_hash_value,
  input  logic [63:0]               in_payload_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               out_hash_out,
  output logic                      out_found,
  output logic [63:0]               out_payload_out,
  output logic [1:0]                out_status
);
  import cht_pkg::*;

  logic [CFG_W-1:0] bucket_count_r;
  logic             q_valid, q_ready, busy;
  op_t              q_op;
  logic [1:0]       q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= CFG_W'(719);
    else if (cfg_we) bucket_count_r <= cfg_wdata;
  end

  cht_front u_front (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_key_byte(in_key_byte), .in_byte_valid(in_byte_valid),
    .in_key_last(in_key_last), .in_hash_value(in_hash_value),
    .in_payload_in(in_payload_in),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_count(q_count)
  );

  cht_back #(.NODE_COUNT(NODE_COUNT), .MAX_BUCKETS(MAX_BUCKETS)) u_back (
    .clk(clk), .rst_n(rst_n), .bucket_count(bucket_count_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .busy(busy),
    .out_valid(out_valid), .out_ready(out_ready), .out_hash_out(out_hash_out),
    .out_found(out_found), .out_payload_out(out_payload_out),
    .out_status(out_status)
  );

  `CHT_ASSERT_NEVER(a_no_accept_in_clear, busy && in_ready, "item taken during clear")
  `CHT_ASSERT_NEVER(a_queue_bound, q_count == 2'd3, "op queue overflow")
  `CHT_ASSERT_NEXT(a_reset_out_idle, !rst_n, !out_valid && busy, "bad state after reset")

endmodule

FILE: rtl/core/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/cht_front.sv
// Front end: hash accumulation over key bytes and a two-entry op queue.
// Depends on cht_pkg.
module cht_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             busy,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_cmd,
  input  logic [7:0]       in_key_byte,
  input  logic             in_byte_valid,
  input  logic             in_key_last,
  input  logic [31:0]      in_hash_value,
  input  logic [63:0]      in_payload_in,
  output logic             q_valid,
  input  logic             q_ready,
  output cht_pkg::op_t     q_op,
  output logic [1:0]       q_count
);
  import cht_pkg::*;

  logic [31:0] acc_r, acc_nxt, acc_upd;
  op_t         q_mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        acc_fire, push, pop;
  op_t         new_op;

  assign in_ready = !busy && (cnt_r != 2'd2);
  assign acc_fire = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = q_mem_r[rp_r];
  assign q_count  = cnt_r;
  assign pop      = q_valid && q_ready;

  always_comb begin
    acc_upd = acc_r;
    if (in_byte_valid)
      acc_upd = (acc_r << 5) - acc_r + {{24{in_key_byte[7]}}, in_key_byte};
    acc_nxt = acc_r;
    push    = 1'b0;
    new_op.cmd     = in_cmd;
    new_op.hash    = (in_cmd >= CMD_GET_H) ? in_hash_value : acc_upd;
    new_op.payload = in_payload_in;
    if (acc_fire) begin
      acc_nxt = in_key_last ? 32'd0 : acc_upd;
      push    = in_key_last && (in_cmd <= CMD_DEL_H);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      acc_r <= acc_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= new_op;
  end

endmodule

FILE: rtl/core/cht_back.sv
// Back end: bucket modulo, chain walk, node allocation and result register.
// Depends on cht_pkg and cht_ram.
module cht_back #(
  parameter int NODE_COUNT  = 1024,
  parameter int MAX_BUCKETS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [cht_pkg::CFG_W-1:0] bucket_count,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  cht_pkg::op_t             q_op,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [31:0]              out_hash_out,
  output logic                     out_found,
  output logic [63:0]              out_payload_out,
  output logic [1:0]               out_status
);
  import cht_pkg::*;

  localparam int NW  = $clog2(NODE_COUNT + 1);
  localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int BW  = $clog2(MAX_BUCKETS);
  localparam int DW  = $clog2(MAX_BUCKETS + 1);
  localparam logic [NW-1:0] NULL_N = NW'(NODE_COUNT);

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [DW-1:0] rem_r, rem_nxt, dvs;
  logic [DW:0]   trial;
  logic [31:0]   sh_r, sh_nxt, bc32, d32;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt, clr_r, clr_nxt;
  logic [NW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, steps_r, steps_nxt;
  logic [NW-1:0] free_r, free_nxt, pool_r, pool_nxt, alloc;
  logic          rfound_r, rfound_nxt;
  logic [63:0]   rpay_r, rpay_nxt;
  logic [1:0]    rstat_r, rstat_nxt;
  logic          ov_r, ov_nxt, load_out;
  logic [31:0]   oh_r;
  logic          of_r;
  logic [63:0]   op_pay_r;
  logic [1:0]    os_r;

  logic            b_we, n_we, l_we;
  logic [BW-1:0]   b_waddr;
  logic [NW-1:0]   b_wdata, b_rdata, l_wdata, l_rdata;
  logic [NAW-1:0]  n_waddr, n_raddr, l_waddr, l_raddr;
  logic [31:0]     h_rdata;
  logic [63:0]     p_rdata;

  assign bc32  = 32'(bucket_count);
  assign d32   = (bc32 == 32'd0) ? 32'd1 : ((bc32 > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS) : bc32);
  assign dvs   = d32[DW-1:0];
  assign trial = {rem_r, sh_r[31]};

  assign busy            = (state_r == ST_CLEAR);
  assign out_valid       = ov_r;
  assign out_hash_out    = oh_r;
  assign out_found       = of_r;
  assign out_payload_out = op_pay_r;
  assign out_status      = os_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    rem_nxt    = rem_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    bkt_nxt    = bkt_r;
    clr_nxt    = clr_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    steps_nxt  = steps_r;
    free_nxt   = free_r;
    pool_nxt   = pool_r;
    rfound_nxt = rfound_r;
    rpay_nxt   = rpay_r;
    rstat_nxt  = rstat_r;
    q_ready    = 1'b0;
    load_out   = 1'b0;
    alloc      = free_r;
    b_we       = 1'b0;
    b_waddr    = bkt_r;
    b_wdata    = NULL_N;
    n_we       = 1'b0;
    n_waddr    = alloc[NAW-1:0];
    n_raddr    = cur_r[NAW-1:0];
    l_we       = 1'b0;
    l_waddr    = alloc[NAW-1:0];
    l_wdata    = b_rdata;
    l_raddr    = free_r[NAW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == MAX_BUCKETS - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          op_nxt    = q_op;
          sh_nxt    = q_op.hash;
          rem_nxt   = '0;
          cnt_nxt   = 5'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = (trial >= {1'b0, dvs}) ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        sh_nxt  = {sh_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          bkt_nxt   = rem_nxt[BW-1:0];
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_nxt = (op_r.cmd == CMD_ADD) ? ST_ADD : ST_FIRST;
      end
      ST_ADD: begin
        rfound_nxt = 1'b0;
        rpay_nxt   = 64'd0;
        rstat_nxt  = STAT_OK;
        state_nxt  = ST_DONE;
        if (free_r < NULL_N) begin
          alloc    = free_r;
          free_nxt = l_rdata;
        end else if (pool_r < NULL_N) begin
          alloc    = pool_r;
          pool_nxt = pool_r + 1'b1;
        end else begin
          rstat_nxt = STAT_FULL;
        end
        if (rstat_nxt == STAT_OK) begin
          n_waddr = alloc[NAW-1:0];
          l_waddr = alloc[NAW-1:0];
          n_we    = 1'b1;
          l_we    = 1'b1;
          l_wdata = b_rdata;
          b_we    = 1'b1;
          b_wdata = alloc;
        end
      end
      ST_FIRST: begin
        rfound_nxt = 1'b0;
        rpay_nxt   = 64'd0;
        rstat_nxt  = STAT_MISS;
        cur_nxt    = b_rdata;
        prev_nxt   = NULL_N;
        steps_nxt  = '0;
        n_raddr    = b_rdata[NAW-1:0];
        state_nxt  = (b_rdata < NULL_N) ? ST_CHECK : ST_DONE;
      end
      ST_CHECK: begin
        n_raddr = l_rdata[NAW-1:0];
        if (h_rdata == op_r.hash) begin
          rfound_nxt = 1'b1;
          rpay_nxt   = p_rdata;
          rstat_nxt  = STAT_OK;
          state_nxt  = ST_DONE;
          if (op_r.cmd == CMD_DEL_KEY || op_r.cmd == CMD_DEL_H) begin
            state_nxt = ST_FREE;
            if (prev_r < NULL_N) begin
              l_we    = 1'b1;
              l_waddr = prev_r[NAW-1:0];
              l_wdata = l_rdata;
            end else begin
              b_we    = 1'b1;
              b_wdata = l_rdata;
            end
          end
        end else begin
          steps_nxt = steps_r + 1'b1;
          prev_nxt  = cur_r;
          cur_nxt   = l_rdata;
          if (!((32'(steps_r) + 32'd1 < NODE_COUNT) && (l_rdata < NULL_N)))
            state_nxt = ST_DONE;
        end
      end
      ST_FREE: begin
        l_we      = 1'b1;
        l_waddr   = cur_r[NAW-1:0];
        l_wdata   = free_r;
        free_nxt  = cur_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_CHECK) l_raddr = l_rdata[NAW-1:0];
    if (state_r == ST_FIRST) l_raddr = b_rdata[NAW-1:0];
    ov_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      free_r  <= NULL_N;
      pool_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
      pool_r  <= pool_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    rem_r    <= rem_nxt;
    sh_r     <= sh_nxt;
    cnt_r    <= cnt_nxt;
    bkt_r    <= bkt_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    steps_r  <= steps_nxt;
    rfound_r <= rfound_nxt;
    rpay_r   <= rpay_nxt;
    rstat_r  <= rstat_nxt;
    if (load_out) begin
      oh_r     <= op_r.hash;
      of_r     <= rfound_r;
      op_pay_r <= rpay_r;
      os_r     <= rstat_r;
    end
  end

  cht_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(bkt_r), .rdata(b_rdata)
  );

  cht_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_hashes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(op_r.hash),
    .raddr(n_raddr), .rdata(h_rdata)
  );

  cht_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_payloads (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(op_r.payload),
    .raddr(n_raddr), .rdata(p_rdata)
  );

  cht_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

endmodule
